/* src/hcfu_pkg.sv */
// ----------------------------------------------------------------------------
// hcfu_pkg
// Shared constants for the hash frequency counter with greedy key removal.
// ----------------------------------------------------------------------------
package hcfu_pkg;

   // default table geometry
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int COUNT_BITS_DEF  = 16;

   // fixed field widths
   localparam int KEY_W    = 32;
   localparam int BUDGET_W = 16;
   localparam int LEFT_W   = 11;

   // item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

endpackage

/* src/hash_count_fewest_unique_left_top.sv */
// ----------------------------------------------------------------------------
// hash_count_fewest_unique_left_top
// Linear-probing frequency counter with greedy removal of low-count keys.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the block can take the next one. An insert item hashes its key, then
// reads and checks one slot per probe, S_RD then S_CHK: a free home slot
// takes one probe, a full table up to TABLE_DEPTH probes. A finish item scans
// the whole table once, plus once more per count value whose keys it removes
// in full, takes the removed keys out one by one, raises rsp_strobe for one
// cycle with the answer, then clears the table. After reset the same
// clearing pass runs first, with busy high.
// Results cannot be held off: rsp_strobe marks the only cycle they are valid.
// csr_ready is always high; write the budget only while idle.
// ----------------------------------------------------------------------------
module hash_count_fewest_unique_left_top import hcfu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_kind,
   input  logic signed [KEY_W-1:0] req_key_value,
   output logic                    rsp_strobe,
   output logic [LEFT_W-1:0]       rsp_unique_left,
   output logic                    rsp_overflow,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [BUDGET_W-1:0]     csr_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (COUNT_BITS > BUDGET_W) ? COUNT_BITS : BUDGET_W;
   localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_V = (AW+1)'(TABLE_DEPTH);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_HASH = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_SCAN = 3'd5;
   localparam logic [2:0] S_TAKE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         probes_ff, probes_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CW-1:0]         distinct_ff, distinct_in;
   logic                  ovf_ff, ovf_in;
   logic [BUDGET_W-1:0]   budget_ff;
   logic [AW:0]           scan_ff, scan_in;
   logic                  vld_ff, vld_in;
   logic [COUNT_BITS-1:0] thr_ff, thr_in;
   logic [COUNT_BITS-1:0] min_ff, min_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [BUDGET_W-1:0]   rem_ff, rem_in;
   logic [CW-1:0]         removed_ff, removed_in;
   logic                  strobe_ff, strobe_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic                  rovf_ff, rovf_in;

   logic                  accept;
   logic                  hash_done;
   logic [AW-1:0]         hash_slot;
   logic [AW-1:0]         rd_addr;
   logic                  rd_used;
   logic [KEY_W-1:0]      rd_key;
   logic [COUNT_BITS-1:0] rd_count;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  wr_used;
   logic [COUNT_BITS-1:0] wr_count;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   hcfu_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start_hash (accept && (req_kind == KIND_INSERT)),
      .key        (req_key_value),
      .done       (hash_done),
      .slot       (hash_slot)
   );

   hcfu_table #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_table (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_used  (rd_used),
      .rd_key   (rd_key),
      .rd_count (rd_count),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_used  (wr_used),
      .wr_key   (key_ff),
      .wr_count (wr_count)
   );

   assign rd_addr = (state_ff == S_SCAN) ? scan_ff[AW-1:0] : idx_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      probes_in   = probes_ff;
      key_in      = key_ff;
      distinct_in = distinct_ff;
      ovf_in      = ovf_ff;
      scan_in     = scan_ff;
      vld_in      = 1'b0;
      thr_in      = thr_ff;
      min_in      = min_ff;
      found_in    = found_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      removed_in  = removed_ff;
      strobe_in   = 1'b0;
      left_in     = left_ff;
      rovf_in     = rovf_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_used     = 1'b0;
      wr_count    = '0;
      unique case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               key_in = req_key_value;
               if (req_kind == KIND_INSERT) begin
                  state_in = S_HASH;
               end else begin
                  state_in   = S_SCAN;
                  scan_in    = '0;
                  thr_in     = '0;
                  found_in   = 1'b0;
                  k_in       = '0;
                  rem_in     = budget_ff;
                  removed_in = '0;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in    = hash_slot;
               probes_in = '0;
               state_in  = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            // probe result: empty slot, hit, table full, or move on
            if (!rd_used) begin
               wr_en       = 1'b1;
               wr_used     = 1'b1;
               wr_count    = COUNT_BITS'(1);
               distinct_in = distinct_ff + 1'b1;
               state_in    = S_IDLE;
            end else if (rd_key == key_ff) begin
               wr_en    = 1'b1;
               wr_used  = 1'b1;
               wr_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;
               state_in = S_IDLE;
            end else if (probes_ff == LAST) begin
               ovf_in   = 1'b1;
               state_in = S_IDLE;
            end else begin
               probes_in = probes_ff + 1'b1;
               idx_in    = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
               state_in  = S_RD;
            end
         end
         S_SCAN: begin
            // smallest count above the threshold and how many keys have it
            if (scan_ff != DEPTH_V) begin
               scan_in = scan_ff + 1'b1;
               vld_in  = 1'b1;
            end
            if (vld_ff && rd_used && (rd_count > thr_ff)) begin
               if (!found_ff || (rd_count < min_ff)) begin
                  min_in   = rd_count;
                  k_in     = CW'(1);
                  found_in = 1'b1;
               end else if (rd_count == min_ff) begin
                  k_in = k_ff + 1'b1;
               end
            end
            if (vld_ff && (scan_ff == DEPTH_V)) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            // remove keys of the current count one by one, rescan, or finish
            if (found_ff && (k_ff == '0)) begin
               thr_in   = min_ff;
               found_in = 1'b0;
               scan_in  = '0;
               state_in = S_SCAN;
            end else if (found_ff && (CMP_W'(rem_ff) >= CMP_W'(min_ff))) begin
               rem_in     = rem_ff - BUDGET_W'(min_ff);
               removed_in = removed_ff + 1'b1;
               k_in       = k_ff - 1'b1;
            end else begin
               strobe_in   = 1'b1;
               left_in     = LEFT_W'(distinct_ff - removed_ff);
               rovf_in     = ovf_ff;
               distinct_in = '0;
               ovf_in      = 1'b0;
               clr_in      = '0;
               state_in    = S_CLR;
            end
         end
         default: begin
            state_in = S_CLR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         distinct_ff <= '0;
         ovf_ff      <= 1'b0;
         budget_ff   <= '0;
         vld_ff      <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         distinct_ff <= distinct_in;
         ovf_ff      <= ovf_in;
         vld_ff      <= vld_in;
         strobe_ff   <= strobe_in;
         if (csr_valid && csr_ready) begin
            budget_ff <= csr_data;
         end
      end
      idx_ff     <= idx_in;
      probes_ff  <= probes_in;
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      thr_ff     <= thr_in;
      min_ff     <= min_in;
      found_ff   <= found_in;
      k_ff       <= k_in;
      rem_ff     <= rem_in;
      removed_ff <= removed_in;
      left_ff    <= left_in;
      rovf_ff    <= rovf_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_unique_left = left_ff;
   assign rsp_overflow    = rovf_ff;

`ifndef SYNTHESIS
   // an accepted item always makes the block busy
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("not busy after accepted item");

   // a result is one cycle wide
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // a result follows only the end of the removal loop
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_TAKE))
      else $error("result outside finish");

   // after a result the table is being cleared
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == S_CLR) && busy)
      else $error("no clearing pass after result");

   // removed keys never exceed distinct keys
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAKE) |-> (removed_ff <= distinct_ff))
      else $error("removed more keys than stored");
`endif

endmodule

/* src/hcfu_table.sv */
// ----------------------------------------------------------------------------
// hcfu_table
// Slot memory: used flag, key and count per slot; one write, one
// registered read per cycle.
// ----------------------------------------------------------------------------
module hcfu_table import hcfu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic                           rd_used,
   output logic [KEY_W-1:0]               rd_key,
   output logic [COUNT_BITS-1:0]          rd_count,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic                           wr_used,
   input  logic [KEY_W-1:0]               wr_key,
   input  logic [COUNT_BITS-1:0]          wr_count
);

   localparam int ENTRY_W = 1 + KEY_W + COUNT_BITS;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_used, wr_key, wr_count};
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign {rd_used, rd_key, rd_count} = rd_data_ff;

endmodule

/* src/hcfu_hash.sv */
// ----------------------------------------------------------------------------
// hcfu_hash
// Home slot of a signed key: non-negative remainder modulo the table depth.
// Power-of-two depth takes the low key bits directly, otherwise one key bit per cycle.
// ----------------------------------------------------------------------------
module hcfu_hash import hcfu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_hash,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam logic [AW:0] DEPTH_V = (AW+1)'(TABLE_DEPTH);
   // 2^32 mod depth, folded back for negative keys
   localparam logic [AW:0] OFFS = (AW+1)'((64'd1 << KEY_W) % TABLE_DEPTH);

   logic             run_ff, run_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [AW:0]      acc_ff, acc_in;
   logic [KEY_W-1:0] sh_ff, sh_in;
   logic             neg_ff, neg_in;
   logic             done_ff, done_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [AW:0]      step;
   logic [AW:0]      fixed;

   // one restoring remainder step
   always_comb begin
      step = {acc_ff[AW-1:0], sh_ff[KEY_W-1]};
      if (step >= DEPTH_V) begin
         step = step - DEPTH_V;
      end
      if (!neg_ff) begin
         fixed = step;
      end else if (step >= OFFS) begin
         fixed = step - OFFS;
      end else begin
         fixed = step + DEPTH_V - OFFS;
      end
   end

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      slot_in = slot_ff;
      if (start_hash) begin
         if (POW2) begin
            slot_in = key[AW-1:0];
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
            cnt_in = 6'(KEY_W);
            acc_in = '0;
            sh_in  = key;
            neg_in = key[KEY_W-1];
         end
      end else if (run_ff) begin
         acc_in = step;
         sh_in  = {sh_ff[KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            slot_in = fixed[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      neg_ff  <= neg_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

/* sim/hcfu_checker.sv */
// ----------------------------------------------------------------------------
// hcfu_checker
// Watches the item, result and budget channels of the frequency counter,
// keeps its own copy of the hash table and budget, predicts the answer of
// each finish item and compares every strobed result with the oldest one.
// ----------------------------------------------------------------------------
module hcfu_checker import hcfu_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_kind,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  logic                    rsp_strobe,
   input  logic [LEFT_W-1:0]       rsp_unique_left,
   input  logic                    rsp_overflow,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [BUDGET_W-1:0]     csr_data,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic [LEFT_W-1:0] unique_left;
      logic              overflow;
   } tally_type;

   localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

   // shadow of the table
   logic [KEY_W-1:0]    shadow_key   [TABLE_DEPTH];
   bit                  shadow_used  [TABLE_DEPTH];
   longint              shadow_count [TABLE_DEPTH];
   bit                  shadow_drop;
   logic [BUDGET_W-1:0] shadow_budget;
   tally_type           tally_q[$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      shadow_drop   = 0;
      shadow_budget = '0;
      foreach (shadow_used[i]) shadow_used[i] = 0;
   end

   // non-negative remainder of the signed key
   function automatic int home_of(logic signed [KEY_W-1:0] k);
      int r;
      r = k % TABLE_DEPTH;
      if (r < 0) r += TABLE_DEPTH;
      return r;
   endfunction

   // linear probe with wrap-around; a new key on a full table is dropped
   task automatic count_key(logic signed [KEY_W-1:0] k);
      int idx;
      idx = home_of(k);
      for (int p = 0; p < TABLE_DEPTH; p++) begin
         if (!shadow_used[idx]) begin
            shadow_used[idx]  = 1;
            shadow_key[idx]   = k;
            shadow_count[idx] = 1;
            return;
         end
         if (shadow_key[idx] == k) begin
            if (shadow_count[idx] < COUNT_MAX) shadow_count[idx]++;
            return;
         end
         idx = (idx + 1) % TABLE_DEPTH;
      end
      shadow_drop = 1;
   endtask

   // greedy removal of the lowest counts within the budget
   function automatic tally_type tally_table();
      longint    counts[$];
      longint    total;
      int        removed;
      tally_type t;
      total   = 0;
      removed = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (shadow_used[i]) counts.push_back(shadow_count[i]);
      counts.sort();
      foreach (counts[i]) begin
         total += counts[i];
         if (total > shadow_budget) break;
         removed++;
      end
      t.unique_left = LEFT_W'(counts.size() - removed);
      t.overflow    = shadow_drop;
      return t;
   endfunction

   always @(posedge clock) begin
      tally_type want;
      if (!reset) begin
         // budget writes
         if (csr_valid && csr_ready) shadow_budget = csr_data;

         // results against the oldest expectation
         if (rsp_strobe) begin
            if (tally_q.size() == 0) begin
               $display("%0t: unexpected result unique_left %0d overflow %0d",
                        $time, rsp_unique_left, rsp_overflow);
               fail_count <= fail_count + 1;
            end else begin
               want = tally_q.pop_front();
               if (rsp_unique_left !== want.unique_left ||
                   rsp_overflow !== want.overflow) begin
                  $display("%0t: expected unique_left %0d overflow %0d, actual %0d %0d",
                           $time, want.unique_left, want.overflow,
                           rsp_unique_left, rsp_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end

         // accepted items
         if (start && !busy) begin
            if (req_kind == KIND_FINISH) begin
               tally_q.push_back(tally_table());
               foreach (shadow_used[i]) shadow_used[i] = 0;
               shadow_drop = 0;
            end else begin
               count_key(req_key_value);
            end
         end
         pending <= tally_q.size();
      end
   end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the hash frequency counter: directed extremes, a full table
// and random load/finish phases with random budgets and random idle gaps.
// The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import hcfu_pkg::*;

   localparam int     DEPTH     = TABLE_DEPTH_DEF;
   localparam longint LIMIT     = 6000000;
   localparam int     RAND_ITEMS = 600;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_kind;
   logic signed [KEY_W-1:0] req_key_value;
   logic                    rsp_strobe;
   logic [LEFT_W-1:0]       rsp_unique_left;
   logic                    rsp_overflow;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [BUDGET_W-1:0]     csr_data;
   int                      fail_count;
   int                      pending;
   longint                  cycles;
   int                      rand_sent;
   bit                      gaps_on;

   hash_count_fewest_unique_left_top dut (
      .clock, .reset, .start, .busy, .req_kind, .req_key_value,
      .rsp_strobe, .rsp_unique_left, .rsp_overflow,
      .csr_valid, .csr_ready, .csr_data
   );

   hcfu_checker chk (
      .clock, .reset, .start, .busy, .req_kind, .req_key_value,
      .rsp_strobe, .rsp_unique_left, .rsp_overflow,
      .csr_valid, .csr_ready, .csr_data, .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // random idle gap, mostly short, a few long
   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return;
      start <= 1'b0;
      if (r < 90) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 60)) @(posedge clock);
   endtask

   // one item, held until the block takes it
   task automatic send(logic kind, logic [KEY_W-1:0] key);
      start         <= 1'b1;
      req_kind      <= kind;
      req_key_value <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      idle_gap();
   endtask

   // wait until the block is idle and every answer is in
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(logic [BUDGET_W-1:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // keys: colliding small pool, aliases of a home slot, full random
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 15) - 8;
      if (r < 60) return $urandom_range(0, 3) + DEPTH * ($urandom_range(0, 6) - 3);
      return $urandom;
   endfunction

   function automatic logic [BUDGET_W-1:0] pick_budget(int n);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      if (r < 20) return BUDGET_W'($urandom);
      return BUDGET_W'($urandom_range(0, n));
   endfunction

   initial begin
      int n;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_INSERT;
      req_key_value = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      gaps_on       = 1;
      rand_sent     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // finish on an empty table
      send(KIND_FINISH, 32'h5a5a_0001);
      // extreme keys with budget zero
      send(KIND_INSERT, 32'h0000_0000);
      send(KIND_INSERT, 32'hffff_ffff);
      send(KIND_INSERT, 32'h7fff_ffff);
      send(KIND_INSERT, 32'h8000_0000);
      send(KIND_INSERT, 32'h0000_0400);
      send(KIND_INSERT, 32'hffff_fc00);
      send(KIND_INSERT, 32'hffff_ffff);
      send(KIND_INSERT, 32'h0000_0000);
      send(KIND_FINISH, 32'hffff_ffff);
      // partial removal
      write_budget(16'd3);
      send(KIND_INSERT, 32'd5);
      send(KIND_INSERT, 32'd1029);
      send(KIND_INSERT, 32'd1029);
      send(KIND_INSERT, -32'sd1019);
      send(KIND_INSERT, -32'sd1019);
      send(KIND_INSERT, -32'sd1019);
      send(KIND_FINISH, 32'd0);
      // budget covers every key
      write_budget(16'hffff);
      send(KIND_INSERT, 32'd9);
      send(KIND_INSERT, 32'd10);
      send(KIND_FINISH, 32'd0);

      // full table, then a new key is dropped
      write_budget(16'd1000);
      gaps_on = 0;
      for (int i = 0; i < DEPTH; i++) send(KIND_INSERT, i);
      gaps_on = 1;
      send(KIND_INSERT, 32'd3000);
      send(KIND_INSERT, -32'sd5);
      send(KIND_INSERT, 32'd7);
      send(KIND_FINISH, 32'd0);

      // random load/finish phases
      while (rand_sent < RAND_ITEMS) begin
         n = $urandom_range(0, 60);
         write_budget(pick_budget(n));
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 49) == 0) send(KIND_FINISH, $urandom);
            else send(KIND_INSERT, pick_key());
         end
         send(KIND_FINISH, $urandom);
         rand_sent += n + 1;
      end

      // drain and watch for stray results
      settle();
      repeat (2 * DEPTH + 100) @(posedge clock);
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
